// ----- rtl/min_max_contrast_stretch_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contrast stretch unit
// Simulation-only checks; the synthesis variants expand to nothing.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_CONTRAST_STRETCH_UNIT_DEFINES_SVH
`define MIN_MAX_CONTRAST_STRETCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CHECK_IMPLY(label, clk, rst, ante, cons)
`define CHECK_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared constants and types of the min/max contrast stretch unit.
// ----------------------------------------------------------------------------
package mmcs_pkg;

   localparam int MAX_PIXELS = 4096;
   localparam int PIX_W      = 8;
   localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int PROD_W     = 2 * PIX_W;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/mmcs_ram.sv -----
// ----------------------------------------------------------------------------
// mmcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mmcs_div.sv -----
// ----------------------------------------------------------------------------
// mmcs_div
// Radix-2 restoring divider: 16-bit dividend by 8-bit divisor, 8-bit quotient,
// one quotient bit per cycle. Caller guarantees quotient < 256.
// ----------------------------------------------------------------------------
module mmcs_div import mmcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [PIX_W-1:0]  divisor,
   output logic [PIX_W-1:0]  quotient,
   output div_stat_type      stat
);

   localparam int STEP_W = $clog2(PIX_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  low_ff, low_in;
   logic [PIX_W-1:0]  dsr_ff, dsr_in;
   logic              done_ff, done_in;
   logic [PIX_W:0]    trial;
   logic [PIX_W:0]    diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, low_ff[PIX_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      if (start) begin
         // high byte is already below the divisor, so only 8 steps remain
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[PROD_W-1:PIX_W];
         low_in  = dividend[PIX_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
         low_in  = {low_ff[PIX_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(PIX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = low_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/min_max_contrast_stretch_unit.sv -----
// Read path: a read beat's result passes the RAM read register, stretch setup,
// the bit-serial divide and the output register; flat images skip the divide.
// Load beats are taken every cycle while no read is in flight; a new read beat
// waits until the last result is in the output register, longer on output stall.
// Reset clears count, pointer, min/max and phase; the pixel RAM is not cleared.
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_unit
// Stores one grey image, tracks min/max, stretches pixels to 0..255 unless flat.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_unit import mmcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [PIX_W-1:0] req_pixel_in,
   input  logic             req_last_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_last_out
);

`include "min_max_contrast_stretch_unit_defines.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [PIX_W-1:0] max_ff, max_in;
   logic             complete_ff, complete_in;
   logic [PIX_W-1:0] jmin_ff, jmin_in;
   logic [PIX_W-1:0] jmax_ff, jmax_in;
   logic             fin_ff, fin_in;
   logic [PIX_W-1:0] quot_ff, quot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic             rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              wr_en;
   logic              rd_en;
   logic [PIX_W-1:0]  rd_data;
   logic              div_start;
   logic [PROD_W-1:0] prod;
   logic [PIX_W-1:0]  span;
   logic [PIX_W-1:0]  pclamp;
   logic [PIX_W-1:0]  pdiff;
   logic [CNT_W-1:0]  count_next;
   logic [PIX_W-1:0]  div_quot;
   div_stat_type      div_stat;
   logic              slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign wr_en = accept && !req_kind && !complete_ff &&
                  (count_ff < CNT_W'(MAX_PIXELS));
   assign rd_en = accept && req_kind && complete_ff && (rp_ff < count_ff);

   mmcs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rp_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // stretch setup: clamp, subtract min, times 255 as (d << 8) - d
   always_comb begin
      span   = jmax_ff - jmin_ff;
      pclamp = rd_data;
      if (rd_data < jmin_ff) begin
         pclamp = jmin_ff;
      end
      if (rd_data > jmax_ff) begin
         pclamp = jmax_ff;
      end
      pdiff = pclamp - jmin_ff;
      prod  = {pdiff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, pdiff};
   end

   assign div_start = (state_ff == S_MUL) && (jmax_ff > jmin_ff);

   mmcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (span),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      complete_in  = complete_ff;
      jmin_in      = jmin_ff;
      jmax_in      = jmax_ff;
      fin_in       = fin_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      count_next   = count_ff + CNT_W'(wr_en);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_en) begin
         count_in = count_next;
         if (req_pixel_in < min_ff) begin
            min_in = req_pixel_in;
         end
         if (req_pixel_in > max_ff) begin
            max_in = req_pixel_in;
         end
      end
      // a last mark on a dropped pixel still closes a non-empty image
      if (accept && !req_kind && !complete_ff && req_last_in &&
          (count_next != '0)) begin
         complete_in = 1'b1;
      end

      if (rd_en) begin
         jmin_in  = min_ff;
         jmax_in  = max_ff;
         fin_in   = ((rp_ff + 1'b1) >= count_ff);
         rp_in    = rp_ff + 1'b1;
         state_in = S_MUL;
         if ((rp_ff + 1'b1) >= count_ff) begin
            count_in    = '0;
            rp_in       = '0;
            min_in      = PIX_MAX;
            max_in      = '0;
            complete_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
         end
         S_MUL: begin
            if (jmax_ff > jmin_ff) begin
               state_in = S_DIV;
            end else begin
               quot_in  = rd_data;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               quot_in  = div_quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = quot_ff;
               rsp_last_in  = fin_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         min_ff       <= PIX_MAX;
         max_ff       <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      jmin_ff      <= jmin_in;
      jmax_ff      <= jmax_in;
      fin_ff       <= fin_in;
      quot_ff      <= quot_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last_out  = rsp_last_ff;

   `CHECK_NEXT(a_read_enters_mul, clock, reset, rd_en, state_ff == S_MUL)
   `CHECK_IMPLY(a_done_only_in_div, clock, reset, div_stat.done, state_ff == S_DIV)
   `CHECK_IMPLY(a_complete_nonempty, clock, reset, complete_ff, count_ff != '0)
   `CHECK_IMPLY(a_div_idle_outside, clock, reset, state_ff == S_IDLE, !div_stat.busy)

endmodule
